// ===== sv/hte_pkg.sv =====
// Hub telemetry record encoder: shared types and constants.
// Item structs for both channels, the record set passed to the serialiser,
// quantity kinds, record IDs, framing bytes and reciprocal constants.
package hte_pkg;

    typedef struct packed {
        logic [4:0]         req_type;
        logic signed [31:0] raw_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } out_item_t;

    localparam int NUM_REC = 3;

    // Up to three records produced by one item; nrec of zero with is_end set
    // is a frame close.
    typedef struct packed {
        logic [1:0]                nrec;
        logic                      is_end;
        logic [NUM_REC-1:0][7:0]   id;
        logic [NUM_REC-1:0][15:0]  val;
    } rec_set_t;

    // Quantity kinds
    localparam logic [4:0] KIND_RELALT  = 5'd0;
    localparam logic [4:0] KIND_VSPEED  = 5'd1;
    localparam logic [4:0] KIND_VOLT    = 5'd2;
    localparam logic [4:0] KIND_CURRENT = 5'd3;
    localparam logic [4:0] KIND_RPM     = 5'd4;
    localparam logic [4:0] KIND_TEMP1   = 5'd5;
    localparam logic [4:0] KIND_TEMP2   = 5'd6;
    localparam logic [4:0] KIND_ACCX    = 5'd7;
    localparam logic [4:0] KIND_ACCY    = 5'd8;
    localparam logic [4:0] KIND_ACCZ    = 5'd9;
    localparam logic [4:0] KIND_LAT     = 5'd10;
    localparam logic [4:0] KIND_LON     = 5'd11;
    localparam logic [4:0] KIND_GPSALT  = 5'd12;
    localparam logic [4:0] KIND_SPEED   = 5'd13;
    localparam logic [4:0] KIND_HEADING = 5'd14;
    localparam logic [4:0] KIND_DATE    = 5'd15;
    localparam logic [4:0] KIND_TIME    = 5'd16;
    localparam logic [4:0] KIND_END     = 5'd17;

    // Framing
    localparam logic [7:0] SYNC_BYTE = 8'h5E;
    localparam logic [7:0] ESC_BYTE  = 8'h5D;
    localparam logic [7:0] ESC_XOR   = 8'h60;

    // Record IDs
    localparam logic [7:0] ID_ALT_M      = 8'h10;
    localparam logic [7:0] ID_ALT_CM     = 8'h21;
    localparam logic [7:0] ID_VSPEED     = 8'h30;
    localparam logic [7:0] ID_VOLT       = 8'h39;
    localparam logic [7:0] ID_CURRENT    = 8'h28;
    localparam logic [7:0] ID_RPM        = 8'h03;
    localparam logic [7:0] ID_TEMP1      = 8'h02;
    localparam logic [7:0] ID_TEMP2      = 8'h05;
    localparam logic [7:0] ID_ACCX       = 8'h24;
    localparam logic [7:0] ID_ACCY       = 8'h25;
    localparam logic [7:0] ID_ACCZ       = 8'h26;
    localparam logic [7:0] ID_LAT_DDMM   = 8'h13;
    localparam logic [7:0] ID_LAT_MMMM   = 8'h1B;
    localparam logic [7:0] ID_LAT_HEMI   = 8'h23;
    localparam logic [7:0] ID_LON_DDMM   = 8'h12;
    localparam logic [7:0] ID_LON_MMMM   = 8'h1A;
    localparam logic [7:0] ID_LON_HEMI   = 8'h22;
    localparam logic [7:0] ID_GPSALT_M   = 8'h01;
    localparam logic [7:0] ID_GPSALT_CM  = 8'h09;
    localparam logic [7:0] ID_SPEED_KT   = 8'h11;
    localparam logic [7:0] ID_SPEED_FRAC = 8'h19;
    localparam logic [7:0] ID_HDG_DEG    = 8'h14;
    localparam logic [7:0] ID_HDG_FRAC   = 8'h1C;
    localparam logic [7:0] ID_DAY_MONTH  = 8'h15;
    localparam logic [7:0] ID_YEAR       = 8'h16;
    localparam logic [7:0] ID_HOUR_MIN   = 8'h17;
    localparam logic [7:0] ID_SEC        = 8'h18;

    // Hemisphere letters
    localparam logic [7:0] HEMI_N = 8'h4E;
    localparam logic [7:0] HEMI_S = 8'h53;
    localparam logic [7:0] HEMI_E = 8'h45;
    localparam logic [7:0] HEMI_W = 8'h57;

    // floor(2^(32+s)/D), s = floor(log2 D); estimate is low by at most one
    localparam logic [31:0] RECIP_100  = 32'd2748779069;  // shift 38
    localparam logic [31:0] RECIP_1000 = 32'd2199023255;  // shift 41
    localparam logic [31:0] RECIP_1E5  = 32'd2814749767;  // shift 48
    localparam logic [31:0] RECIP_1E7  = 32'd3602879701;  // shift 55
    // exact /1000 for values below 2^24 (shift 33), exact /10 below 1024 (shift 11)
    localparam logic [23:0] RECIP_MILLI = 24'd8589935;
    localparam logic [7:0]  RECIP_TENTH = 8'd205;

    localparam logic [10:0] KNOT_SCALE = 11'd1944;
    localparam logic [23:0] TEN_MILLION = 24'd10000000;

endpackage

// ===== sv/hub_telemetry_record_encoder.sv =====
// Hub telemetry record encoder: top level.
// Joins the conversion pipeline (hte_arith) and the byte serialiser
// (hte_serializer); depends on hte_pkg.
//
// Each input item is one telemetry quantity; the block turns it into one to
// three hub records and sends them as a byte-stuffed stream, one byte per
// item on the output with last_byte marking the final byte of each input item.
// An item passes ten pipeline stages, the serialiser's record slot and its
// output register before its first byte is offered. The serialiser then
// sends one byte per cycle while the output is not stalled: four bytes per
// record plus one for each escaped data byte, so 4 to 18 bytes per item,
// one byte for a frame close and none for an item that produces nothing.
// The serialiser sets the sustained rate; the pipeline keeps accepting
// items until it fills up (ten in the pipeline, one in the serialiser), and
// the output register is refilled in the same cycle that its byte is taken.
module hub_telemetry_record_encoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hte_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output hte_pkg::out_item_t m_item
);
    import hte_pkg::*;

    logic     rec_valid;
    logic     rec_ready;
    rec_set_t rec;

    hte_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    hte_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== sv/hte_arith.sv =====
// Hub telemetry record encoder: conversion pipeline.
// Ten registered stages turn one quantity into up to three 16-bit records.
// Depends on hte_pkg.
module hte_arith (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hte_pkg::in_item_t s_item,
    output logic              rec_valid,
    input  logic              rec_ready,
    output hte_pkg::rec_set_t rec
);
    import hte_pkg::*;

    localparam int NSTG = 10;

    typedef enum logic [1:0] {
        DIV_100  = 2'd0,
        DIV_1000 = 2'd1,
        DIV_1E5  = 2'd2,
        DIV_1E7  = 2'd3
    } div_sel_t;

    function automatic logic [23:0] div_value(input div_sel_t sel);
        logic [23:0] d;
        case (sel)
            DIV_100:  d = 24'd100;
            DIV_1000: d = 24'd1000;
            DIV_1E5:  d = 24'd100000;
            DIV_1E7:  d = TEN_MILLION;
            default:  d = 24'd100;
        endcase
        return d;
    endfunction

    logic [NSTG-1:0] valid_reg, valid_next, en;

    // stage registers
    in_item_t s0_item_reg;
    in_item_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;
    in_item_t s6_ctl_reg, s7_ctl_reg, s8_ctl_reg, s9_ctl_reg;
    logic [31:0] s1_x_reg, s2_x_reg, s3_x_reg;
    div_sel_t    s1_sel_reg, s2_sel_reg, s3_sel_reg;
    logic [63:0] s2_prod_reg;
    logic [31:0] s3_q_reg, s3_qd_reg;
    logic [31:0] s4_q_reg, s5_q_reg, s6_q_reg, s7_q_reg, s8_q_reg, s9_q_reg;
    logic [23:0] s4_r_reg, s5_r_reg, s6_r_reg, s7_r_reg, s8_r_reg, s9_r_reg;
    logic [29:0] s5_mins_reg, s6_mins_reg, s7_mins_reg;
    logic [61:0] s6_prod_reg;
    logic [6:0]  s7_y_reg, s8_y_reg, s9_y_reg;
    logic [5:0]  s7_q2e_reg, s8_q2_reg, s9_q2_reg;
    logic [29:0] s7_qd2_reg;
    logic [23:0] s8_fr_reg;
    logic [13:0] s9_frd_reg;

    // next values
    logic [31:0] s1_x_next;
    div_sel_t    s1_sel_next;
    logic [63:0] s2_prod_next;
    logic [31:0] s3_q_next, s3_qd_next;
    logic [31:0] s4_q_next;
    logic [23:0] s4_r_next;
    logic [29:0] s5_mins_next;
    logic [61:0] s6_prod_next;
    logic [6:0]  s7_y_next;
    logic [5:0]  s7_q2e_next, s8_q2_next;
    logic [29:0] s7_qd2_next;
    logic [23:0] s8_fr_next;
    logic [13:0] s9_frd_next;

    // ---------------- flow control ----------------
    always_comb begin
        en[NSTG-1] = !valid_reg[NSTG-1] || rec_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign s_ready   = en[0];
    assign rec_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // ---------------- datapath ----------------
    logic [31:0] s0_u, s0_abs;
    logic [42:0] s0_knots_full;
    logic [55:0] s3_qd_full;
    logic [31:0] s4_r_est, s4_div;
    logic [29:0] s5_opnd;
    logic [31:0] s5_mconst;
    logic [29:0] s8_rem;
    logic [47:0] s9_prod;

    always_comb begin
        // stage 1: magnitude or knot scaling, pick divisor
        s0_u          = s0_item_reg.raw_value;
        s0_abs        = s0_u[31] ? 32'd0 - s0_u : s0_u;
        s0_knots_full = 43'(s0_u) * 43'(KNOT_SCALE);
        s1_x_next     = (s0_item_reg.req_type == KIND_SPEED) ? s0_knots_full[31:0] : s0_abs;
        case (s0_item_reg.req_type)
            KIND_GPSALT:               s1_sel_next = DIV_1000;
            KIND_SPEED, KIND_HEADING:  s1_sel_next = DIV_1E5;
            KIND_LAT, KIND_LON:        s1_sel_next = DIV_1E7;
            default:                   s1_sel_next = DIV_100;
        endcase

        // stage 2: reciprocal multiply
        case (s1_sel_reg)
            DIV_100:  s2_prod_next = s1_x_reg * RECIP_100;
            DIV_1000: s2_prod_next = s1_x_reg * RECIP_1000;
            DIV_1E5:  s2_prod_next = s1_x_reg * RECIP_1E5;
            DIV_1E7:  s2_prod_next = s1_x_reg * RECIP_1E7;
            default:  s2_prod_next = s1_x_reg * RECIP_100;
        endcase

        // stage 3: quotient estimate and its back-product
        case (s2_sel_reg)
            DIV_100:  s3_q_next = 32'(s2_prod_reg >> 38);
            DIV_1000: s3_q_next = 32'(s2_prod_reg >> 41);
            DIV_1E5:  s3_q_next = 32'(s2_prod_reg >> 48);
            DIV_1E7:  s3_q_next = 32'(s2_prod_reg >> 55);
            default:  s3_q_next = 32'(s2_prod_reg >> 38);
        endcase
        s3_qd_full = s3_q_next * div_value(s2_sel_reg);
        s3_qd_next = s3_qd_full[31:0];

        // stage 4: one correction step
        s4_r_est = s3_x_reg - s3_qd_reg;
        s4_div   = {8'd0, div_value(s3_sel_reg)};
        if (s4_r_est >= s4_div) begin
            s4_q_next = s3_q_reg + 32'd1;
            s4_r_next = 24'(s4_r_est - s4_div);
        end else begin
            s4_q_next = s3_q_reg;
            s4_r_next = s4_r_est[23:0];
        end

        // stage 5: fractional degrees to minutes (x1e7)
        s5_mins_next = 30'(s4_r_reg) * 30'd60;

        // stage 6: second reciprocal multiply, constant chosen by kind
        if (s5_ctl_reg.req_type inside {KIND_LAT, KIND_LON}) begin
            s5_opnd   = s5_mins_reg;
            s5_mconst = RECIP_1E7;
        end else if (s5_ctl_reg.req_type == KIND_GPSALT) begin
            s5_opnd   = {6'd0, s5_r_reg};
            s5_mconst = {24'd0, RECIP_TENTH};
        end else begin
            s5_opnd   = {6'd0, s5_r_reg};
            s5_mconst = {8'd0, RECIP_MILLI};
        end
        s6_prod_next = s5_opnd * s5_mconst;

        // stage 7: small quotients
        s7_y_next   = (s6_ctl_reg.req_type == KIND_GPSALT) ? s6_prod_reg[17:11]
                                                           : s6_prod_reg[39:33];
        s7_q2e_next = s6_prod_reg[60:55];
        s7_qd2_next = 30'(s7_q2e_next) * 30'(TEN_MILLION);

        // stage 8: correct whole minutes
        s8_rem = s7_mins_reg - s7_qd2_reg;
        if (s8_rem >= 30'(TEN_MILLION)) begin
            s8_q2_next = s7_q2e_reg + 6'd1;
            s8_fr_next = 24'(s8_rem - 30'(TEN_MILLION));
        end else begin
            s8_q2_next = s7_q2e_reg;
            s8_fr_next = s8_rem[23:0];
        end

        // stage 9: minute fraction in 1e-4 units
        s9_prod     = s8_fr_reg * RECIP_MILLI;
        s9_frd_next = s9_prod[46:33];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_item_reg <= s_item;
        end
        if (en[1]) begin
            s1_ctl_reg <= s0_item_reg;
            s1_x_reg   <= s1_x_next;
            s1_sel_reg <= s1_sel_next;
        end
        if (en[2]) begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_x_reg    <= s1_x_reg;
            s2_sel_reg  <= s1_sel_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (en[3]) begin
            s3_ctl_reg <= s2_ctl_reg;
            s3_x_reg   <= s2_x_reg;
            s3_sel_reg <= s2_sel_reg;
            s3_q_reg   <= s3_q_next;
            s3_qd_reg  <= s3_qd_next;
        end
        if (en[4]) begin
            s4_ctl_reg <= s3_ctl_reg;
            s4_q_reg   <= s4_q_next;
            s4_r_reg   <= s4_r_next;
        end
        if (en[5]) begin
            s5_ctl_reg  <= s4_ctl_reg;
            s5_q_reg    <= s4_q_reg;
            s5_r_reg    <= s4_r_reg;
            s5_mins_reg <= s5_mins_next;
        end
        if (en[6]) begin
            s6_ctl_reg  <= s5_ctl_reg;
            s6_q_reg    <= s5_q_reg;
            s6_r_reg    <= s5_r_reg;
            s6_mins_reg <= s5_mins_reg;
            s6_prod_reg <= s6_prod_next;
        end
        if (en[7]) begin
            s7_ctl_reg  <= s6_ctl_reg;
            s7_q_reg    <= s6_q_reg;
            s7_r_reg    <= s6_r_reg;
            s7_mins_reg <= s6_mins_reg;
            s7_y_reg    <= s7_y_next;
            s7_q2e_reg  <= s7_q2e_next;
            s7_qd2_reg  <= s7_qd2_next;
        end
        if (en[8]) begin
            s8_ctl_reg <= s7_ctl_reg;
            s8_q_reg   <= s7_q_reg;
            s8_r_reg   <= s7_r_reg;
            s8_y_reg   <= s7_y_reg;
            s8_q2_reg  <= s8_q2_next;
            s8_fr_reg  <= s8_fr_next;
        end
        if (en[9]) begin
            s9_ctl_reg <= s8_ctl_reg;
            s9_q_reg   <= s8_q_reg;
            s9_r_reg   <= s8_r_reg;
            s9_y_reg   <= s8_y_reg;
            s9_q2_reg  <= s8_q2_reg;
            s9_frd_reg <= s9_frd_next;
        end
    end

    // ---------------- record assembly ----------------
    logic        neg;
    logic [31:0] raw;
    logic [15:0] q16, sq16, y16, sy16, alt_m, ddmm;

    always_comb begin
        raw   = s9_ctl_reg.raw_value;
        neg   = raw[31];
        q16   = s9_q_reg[15:0];
        sq16  = neg ? 16'd0 - q16 : q16;
        y16   = {9'd0, s9_y_reg};
        sy16  = neg ? 16'd0 - y16 : y16;
        // negative altitude rounds the metres away from zero at half a metre
        alt_m = neg ? 16'd0 - (q16 + {15'd0, (s9_r_reg >= 24'd50)}) : q16;
        ddmm  = 16'(q16 * 16'd100) + {10'd0, s9_q2_reg};

        rec = '0;
        case (s9_ctl_reg.req_type)
            KIND_RELALT: begin
                rec.nrec   = 2'd2;
                rec.id[0]  = ID_ALT_M;
                rec.val[0] = alt_m;
                rec.id[1]  = ID_ALT_CM;
                rec.val[1] = s9_r_reg[15:0];
            end
            KIND_VSPEED: begin
                rec.nrec = 2'd1; rec.id[0] = ID_VSPEED; rec.val[0] = raw[15:0];
            end
            KIND_VOLT: begin
                rec.nrec = 2'd1; rec.id[0] = ID_VOLT; rec.val[0] = sq16;
            end
            KIND_CURRENT: begin
                rec.nrec = 2'd1; rec.id[0] = ID_CURRENT; rec.val[0] = sq16;
            end
            KIND_RPM: begin
                rec.nrec = 2'd1; rec.id[0] = ID_RPM; rec.val[0] = raw[15:0];
            end
            KIND_TEMP1: begin
                rec.nrec = 2'd1; rec.id[0] = ID_TEMP1; rec.val[0] = raw[15:0];
            end
            KIND_TEMP2: begin
                rec.nrec = 2'd1; rec.id[0] = ID_TEMP2; rec.val[0] = raw[15:0];
            end
            KIND_ACCX: begin
                rec.nrec = 2'd1; rec.id[0] = ID_ACCX; rec.val[0] = raw[15:0];
            end
            KIND_ACCY: begin
                rec.nrec = 2'd1; rec.id[0] = ID_ACCY; rec.val[0] = raw[15:0];
            end
            KIND_ACCZ: begin
                rec.nrec = 2'd1; rec.id[0] = ID_ACCZ; rec.val[0] = raw[15:0];
            end
            KIND_LAT: begin
                rec.nrec   = 2'd3;
                rec.id[0]  = ID_LAT_DDMM;
                rec.val[0] = ddmm;
                rec.id[1]  = ID_LAT_MMMM;
                rec.val[1] = {2'd0, s9_frd_reg};
                rec.id[2]  = ID_LAT_HEMI;
                rec.val[2] = {8'd0, neg ? HEMI_S : HEMI_N};
            end
            KIND_LON: begin
                rec.nrec   = 2'd3;
                rec.id[0]  = ID_LON_DDMM;
                rec.val[0] = ddmm;
                rec.id[1]  = ID_LON_MMMM;
                rec.val[1] = {2'd0, s9_frd_reg};
                rec.id[2]  = ID_LON_HEMI;
                rec.val[2] = {8'd0, neg ? HEMI_W : HEMI_E};
            end
            KIND_GPSALT: begin
                rec.nrec   = 2'd2;
                rec.id[0]  = ID_GPSALT_M;
                rec.val[0] = sq16;
                rec.id[1]  = ID_GPSALT_CM;
                rec.val[1] = y16;
            end
            KIND_SPEED: begin
                rec.nrec   = 2'd2;
                rec.id[0]  = ID_SPEED_KT;
                rec.val[0] = q16;
                rec.id[1]  = ID_SPEED_FRAC;
                rec.val[1] = y16;
            end
            KIND_HEADING: begin
                rec.nrec   = 2'd2;
                rec.id[0]  = ID_HDG_DEG;
                rec.val[0] = sq16;
                rec.id[1]  = ID_HDG_FRAC;
                rec.val[1] = sy16;
            end
            KIND_DATE: begin
                rec.nrec   = 2'd2;
                rec.id[0]  = ID_DAY_MONTH;
                rec.val[0] = {raw[23:16], raw[15:8]};
                rec.id[1]  = ID_YEAR;
                rec.val[1] = {8'd0, raw[31:24]};
            end
            KIND_TIME: begin
                rec.nrec   = 2'd2;
                rec.id[0]  = ID_HOUR_MIN;
                rec.val[0] = {raw[23:16], raw[31:24]};
                rec.id[1]  = ID_SEC;
                rec.val[1] = {8'd0, raw[15:8]};
            end
            KIND_END: begin
                rec.is_end = 1'b1;
            end
            default: begin
                rec = '0;
            end
        endcase
    end

endmodule

// ===== sv/hte_serializer.sv =====
// Hub telemetry record encoder: byte serialiser.
// Holds one record set and sends it as a byte-stuffed stream, one byte a
// cycle while the output is not stalled. Depends on hte_pkg.
module hte_serializer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rec_valid,
    output logic               rec_ready,
    input  hte_pkg::rec_set_t  rec,
    output logic               m_valid,
    input  logic               m_ready,
    output hte_pkg::out_item_t m_item
);
    import hte_pkg::*;

    typedef enum logic [3:0] {
        PH_SYNC = 4'b0001,
        PH_ID   = 4'b0010,
        PH_LO   = 4'b0100,
        PH_HI   = 4'b1000
    } phase_t;

    logic      slot_valid_reg, slot_valid_next;
    rec_set_t  slot_reg, slot_next;
    logic [1:0] rec_idx_reg, rec_idx_next;
    phase_t    phase_reg, phase_next;
    logic      esc_reg, esc_next;
    logic      frame_reg, frame_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    logic [15:0] cur_val;
    logic [7:0]  cur_id, data_b, tx_b;
    logic        prefix, last_rec, end_mode, silent, out_free, emit, is_final, finish;

    always_comb begin
        cur_val  = slot_reg.val[rec_idx_reg];
        cur_id   = slot_reg.id[rec_idx_reg];
        data_b   = (phase_reg == PH_HI) ? cur_val[15:8] : cur_val[7:0];
        prefix   = (data_b == SYNC_BYTE || data_b == ESC_BYTE) && !esc_reg;
        last_rec = rec_idx_reg == slot_reg.nrec - 2'd1;
        end_mode = slot_reg.nrec == 2'd0;
        // an empty frame close or an unknown kind sends nothing
        silent   = end_mode && !(slot_reg.is_end && frame_reg);
        out_free = !m_valid_reg || m_ready;
        emit     = slot_valid_reg && !silent && out_free;

        case (phase_reg)
            PH_SYNC: tx_b = SYNC_BYTE;
            PH_ID:   tx_b = cur_id;
            PH_LO, PH_HI: begin
                if (prefix) begin
                    tx_b = ESC_BYTE;
                end else if (esc_reg) begin
                    tx_b = data_b ^ ESC_XOR;
                end else begin
                    tx_b = data_b;
                end
            end
            default: tx_b = SYNC_BYTE;
        endcase
        if (end_mode) begin
            tx_b = SYNC_BYTE;
        end

        is_final  = end_mode || (phase_reg == PH_HI && !prefix && last_rec);
        finish    = slot_valid_reg && (silent || (emit && is_final));
        rec_ready = !slot_valid_reg || finish;

        slot_valid_next = slot_valid_reg;
        slot_next       = slot_reg;
        rec_idx_next    = rec_idx_reg;
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        frame_next      = frame_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            m_item_next  = '{tx_byte: tx_b, last_byte: is_final};
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (emit && !end_mode) begin
            frame_next = 1'b1;
            case (phase_reg)
                PH_SYNC: phase_next = PH_ID;
                PH_ID:   phase_next = PH_LO;
                PH_LO: begin
                    if (prefix) begin
                        esc_next = 1'b1;
                    end else begin
                        esc_next   = 1'b0;
                        phase_next = PH_HI;
                    end
                end
                PH_HI: begin
                    if (prefix) begin
                        esc_next = 1'b1;
                    end else begin
                        esc_next     = 1'b0;
                        phase_next   = PH_SYNC;
                        rec_idx_next = rec_idx_reg + 2'd1;
                    end
                end
                default: phase_next = PH_SYNC;
            endcase
        end

        if (finish && slot_reg.is_end) begin
            frame_next = 1'b0;
        end

        if (rec_ready) begin
            slot_valid_next = rec_valid;
            slot_next       = rec;
            rec_idx_next    = 2'd0;
            phase_next      = PH_SYNC;
            esc_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
            rec_idx_reg    <= 2'd0;
            phase_reg      <= PH_SYNC;
            esc_reg        <= 1'b0;
            frame_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            rec_idx_reg    <= rec_idx_next;
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            frame_reg      <= frame_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
